// ===== hdl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared types and constants for the pulse and press event detector.
// ----------------------------------------------------------------------------
package ppd_pkg;

    // Result codes
    typedef enum logic [1:0] {
        EV_BEAT       = 2'd0,
        EV_TAP        = 2'd1,
        EV_LONG_PRESS = 2'd2,
        EV_LONG_STOP  = 2'd3
    } event_t;

    // Source tags
    localparam logic [1:0] SENSOR_PULSE = 2'd0;
    localparam logic [1:0] SENSOR_FORCE = 2'd1;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BEAT_HIGH   = 3'd0,
        CFG_BEAT_LOW    = 3'd1,
        CFG_BEAT_GAP    = 3'd2,
        CFG_BEAT_WINDOW = 3'd3,
        CFG_TOUCH_LEVEL = 3'd4,
        CFG_PRESS_LEVEL = 3'd5,
        CFG_TAP_MAX     = 3'd6,
        CFG_REPEAT_GAP  = 3'd7
    } cfg_idx_t;

    // Register widths
    localparam int LEVEL_BITS  = 12;
    localparam int GAP_BITS    = 16;
    localparam int WINDOW_BITS = 20;
    localparam int COUNT_BITS  = 16;

    // Reset values
    localparam logic [LEVEL_BITS-1:0]  RST_BEAT_HIGH   = 12'd2000;
    localparam logic [LEVEL_BITS-1:0]  RST_BEAT_LOW    = 12'd1000;
    localparam logic [GAP_BITS-1:0]    RST_BEAT_GAP    = 16'd300;
    localparam logic [WINDOW_BITS-1:0] RST_BEAT_WINDOW = 20'd15000;
    localparam logic [LEVEL_BITS-1:0]  RST_TOUCH_LEVEL = 12'd100;
    localparam logic [LEVEL_BITS-1:0]  RST_PRESS_LEVEL = 12'd400;
    localparam logic [GAP_BITS-1:0]    RST_TAP_MAX     = 16'd500;
    localparam logic [WINDOW_BITS-1:0] RST_REPEAT_GAP  = 20'd3000;

    // Fixed thresholds
    localparam logic [GAP_BITS-1:0]   LONG_HOLD = 16'd800;
    localparam logic [COUNT_BITS-1:0] MIN_BEATS = 16'd10;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

endpackage

// ===== hdl/pulse_and_press_event_detector.sv =====
// ----------------------------------------------------------------------------
// pulse_and_press_event_detector
// Beat detection on pulse samples and tap / long press timing on force samples.
// ----------------------------------------------------------------------------
// An accepted request waits in the input register; its event (if any) is
//   written to the result register once free and shown on m_valid until taken.
// Throughput: one request per cycle; a request whose event finds the result
//   register still full waits in the input register and holds s_ready low.
// Reset: aresetn synchronous, active low; clears all tracking state and
//   restores the default thresholds. No clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_and_press_event_detector #(
    parameter int SAMPLE_BITS = 12,
    parameter int TIME_BITS   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [ppd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ppd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // sample requests
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_sensor,
    input  logic [SAMPLE_BITS-1:0]              s_sample,
    input  logic [TIME_BITS-1:0]                s_now,
    // event results
    output logic                                m_valid,
    input  logic                                m_ready,
    output ppd_pkg::event_t                     m_event_res
);
    import ppd_pkg::*;

    // Common compare widths
    localparam int LW = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int TW = (TIME_BITS > WINDOW_BITS) ? TIME_BITS : WINDOW_BITS;
    localparam int RW = COUNT_BITS + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LEVEL_BITS-1:0]  beat_high_reg, beat_low_reg;
    logic [LEVEL_BITS-1:0]  touch_level_reg, press_level_reg;
    logic [GAP_BITS-1:0]    beat_gap_reg, tap_max_reg;
    logic [WINDOW_BITS-1:0] beat_window_reg, repeat_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_high_reg   <= RST_BEAT_HIGH;
            beat_low_reg    <= RST_BEAT_LOW;
            beat_gap_reg    <= RST_BEAT_GAP;
            beat_window_reg <= RST_BEAT_WINDOW;
            touch_level_reg <= RST_TOUCH_LEVEL;
            press_level_reg <= RST_PRESS_LEVEL;
            tap_max_reg     <= RST_TAP_MAX;
            repeat_gap_reg  <= RST_REPEAT_GAP;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BEAT_HIGH:   beat_high_reg   <= cfg_wdata[LEVEL_BITS-1:0];
                CFG_BEAT_LOW:    beat_low_reg    <= cfg_wdata[LEVEL_BITS-1:0];
                CFG_BEAT_GAP:    beat_gap_reg    <= cfg_wdata[GAP_BITS-1:0];
                CFG_BEAT_WINDOW: beat_window_reg <= cfg_wdata[WINDOW_BITS-1:0];
                CFG_TOUCH_LEVEL: touch_level_reg <= cfg_wdata[LEVEL_BITS-1:0];
                CFG_PRESS_LEVEL: press_level_reg <= cfg_wdata[LEVEL_BITS-1:0];
                CFG_TAP_MAX:     tap_max_reg     <= cfg_wdata[GAP_BITS-1:0];
                CFG_REPEAT_GAP:  repeat_gap_reg  <= cfg_wdata[WINDOW_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register: holds one sample request for the compute step
    // ------------------------------------------------------------------
    logic                   in_valid_reg;
    logic [1:0]             in_sensor_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TIME_BITS-1:0]   in_now_reg;

    // Result register
    logic   out_valid_reg;
    event_t out_event_reg;

    // Tracking state
    logic                   armed_reg;
    logic [TIME_BITS-1:0]   last_beat_reg, last_reject_reg;
    logic [COUNT_BITS-1:0]  beat_total_reg, false_total_reg;
    logic                   touch_reg;
    logic [TIME_BITS-1:0]   touch_start_reg, long_press_time_reg;
    logic                   long_seen_reg;

    // Next values
    logic                   armed_next;
    logic [TIME_BITS-1:0]   last_beat_next, last_reject_next;
    logic [COUNT_BITS-1:0]  beat_total_next, false_total_next;
    logic                   touch_next;
    logic [TIME_BITS-1:0]   touch_start_next, long_press_time_next;
    logic                   long_seen_next;
    logic                   res_valid;
    event_t                 res_event;

    // Handshake: the compute step retires when it has no event or the
    // result register is free (empty or being taken this cycle).
    logic out_free, advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (out_free || !res_valid);
    assign s_ready  = !in_valid_reg || advance;

    assign m_valid     = out_valid_reg;
    assign m_event_res = out_event_reg;

    // 4*f > 3*b, with b at least the minimum beat count
    function automatic logic ratio_bad(input logic [COUNT_BITS-1:0] b,
                                       input logic [COUNT_BITS-1:0] f);
        logic [RW-1:0] f4, b3;
        f4 = {f, 2'b00};
        b3 = {2'b00, b} + {1'b0, b, 1'b0};
        return (b >= MIN_BEATS) && (f4 > b3);
    endfunction

    // ------------------------------------------------------------------
    // Per-sample update
    // ------------------------------------------------------------------
    logic [TIME_BITS-1:0]  el_beat, el_reject, el_touch, el_long;
    logic [COUNT_BITS-1:0] bt_clr, ft_clr, bt_inc, ft_inc;
    logic [LW-1:0]         smp;

    assign el_beat   = in_now_reg - last_beat_reg;
    assign el_reject = in_now_reg - last_reject_reg;
    assign el_touch  = in_now_reg - touch_start_reg;
    assign el_long   = in_now_reg - long_press_time_reg;
    assign smp       = LW'(in_sample_reg);

    always_comb begin
        // window expiry, then ratio check, on every sample
        bt_clr = beat_total_reg;
        ft_clr = false_total_reg;
        if (TW'(el_beat) >= TW'(beat_window_reg)) begin
            bt_clr = '0;
            ft_clr = '0;
        end
        if (ratio_bad(bt_clr, ft_clr)) begin
            bt_clr = '0;
            ft_clr = '0;
        end

        bt_inc = (bt_clr != COUNT_MAX) ? bt_clr + 1'b1 : bt_clr;
        ft_inc = ((TW'(el_reject) <= TW'(beat_gap_reg)) && (ft_clr != COUNT_MAX))
                 ? ft_clr + 1'b1 : ft_clr;

        armed_next           = armed_reg;
        last_beat_next       = last_beat_reg;
        last_reject_next     = last_reject_reg;
        beat_total_next      = bt_clr;
        false_total_next     = ft_clr;
        touch_next           = touch_reg;
        touch_start_next     = touch_start_reg;
        long_press_time_next = long_press_time_reg;
        long_seen_next       = long_seen_reg;
        res_valid            = 1'b0;
        res_event            = EV_BEAT;

        case (in_sensor_reg)
            SENSOR_PULSE: begin
                if (!armed_reg) begin
                    if (smp > LW'(beat_high_reg)) begin
                        if (TW'(el_beat) > TW'(beat_gap_reg)) begin
                            armed_next       = 1'b1;
                            last_beat_next   = in_now_reg;
                            beat_total_next  = bt_inc;
                            false_total_next = ft_inc;
                            if ((bt_inc >= MIN_BEATS) && !ratio_bad(bt_inc, ft_inc)) begin
                                res_valid = 1'b1;
                                res_event = EV_BEAT;
                            end
                        end else begin
                            last_reject_next = in_now_reg;
                        end
                    end
                end else if (smp < LW'(beat_low_reg)) begin
                    armed_next = 1'b0;
                end
            end
            SENSOR_FORCE: begin
                if (!touch_reg) begin
                    if (smp > LW'(touch_level_reg)) begin
                        touch_next       = 1'b1;
                        touch_start_next = in_now_reg;
                    end
                end else if ((smp > LW'(press_level_reg))
                             && (TW'(el_touch) >= TW'(LONG_HOLD))) begin
                    if (!long_seen_reg || (TW'(el_long) > TW'(repeat_gap_reg))) begin
                        long_press_time_next = in_now_reg;
                        long_seen_next       = 1'b1;
                        res_valid            = 1'b1;
                        res_event            = EV_LONG_PRESS;
                    end
                end else if (smp < LW'(touch_level_reg)) begin
                    res_valid        = 1'b1;
                    res_event        = (TW'(el_touch) <= TW'(tap_max_reg))
                                       ? EV_TAP : EV_LONG_STOP;
                    long_seen_next   = 1'b0;
                    touch_next       = 1'b0;
                    touch_start_next = '0;
                end
            end
            default: begin
                // ignored channels only run the counter checks
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            armed_reg           <= 1'b0;
            last_beat_reg       <= '0;
            last_reject_reg     <= '0;
            beat_total_reg      <= '0;
            false_total_reg     <= '0;
            touch_reg           <= 1'b0;
            touch_start_reg     <= '0;
            long_press_time_reg <= '0;
            long_seen_reg       <= 1'b0;
        end else begin
            // input stage
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end

            // result stage
            if (advance && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            // state commits when the request retires
            if (advance) begin
                armed_reg           <= armed_next;
                last_beat_reg       <= last_beat_next;
                last_reject_reg     <= last_reject_next;
                beat_total_reg      <= beat_total_next;
                false_total_reg     <= false_total_next;
                touch_reg           <= touch_next;
                touch_start_reg     <= touch_start_next;
                long_press_time_reg <= long_press_time_next;
                long_seen_reg       <= long_seen_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sensor_reg <= s_sensor;
            in_sample_reg <= s_sample;
            in_now_reg    <= s_now;
        end
        if (advance && res_valid) begin
            out_event_reg <= res_event;
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pulse_and_press_event_detector. Sample requests are
// queued by phase and driven in random bursts; an in-bench event predictor
// follows every accepted request and each returned event is checked in order
// against the predicted events, under several threshold settings.
// ----------------------------------------------------------------------------
module testbench;
    import ppd_pkg::*;

    localparam int LEVEL_W = 12;
    localparam int STAMP_W = 32;
    localparam int CYCLE_LIMIT = 500000;

    // codes the block passes through without any beat or touch handling
    localparam logic [1:0] SENSOR_IGNORED = 2'd2;
    localparam logic [1:0] SENSOR_SPARE   = 2'd3;

    typedef struct packed {
        logic [1:0]         sensor;
        logic [LEVEL_W-1:0] level;
        logic [STAMP_W-1:0] stamp;
    } sample_req_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0]  beat_high;
        logic [LEVEL_BITS-1:0]  beat_low;
        logic [GAP_BITS-1:0]    beat_gap;
        logic [WINDOW_BITS-1:0] beat_window;
        logic [LEVEL_BITS-1:0]  touch_level;
        logic [LEVEL_BITS-1:0]  press_level;
        logic [GAP_BITS-1:0]    tap_max;
        logic [WINDOW_BITS-1:0] repeat_gap;
    } thresholds_t;

    localparam thresholds_t DEFAULT_THR = '{RST_BEAT_HIGH, RST_BEAT_LOW, RST_BEAT_GAP,
        RST_BEAT_WINDOW, RST_TOUCH_LEVEL, RST_PRESS_LEVEL, RST_TAP_MAX, RST_REPEAT_GAP};

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic [1:0]         s_sensor = '0;
    logic [LEVEL_W-1:0] s_sample = '0;
    logic [STAMP_W-1:0] s_now    = '0;

    logic   m_valid;
    logic   m_ready = 1'b0;
    event_t m_event_res;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    pulse_and_press_event_detector #(
        .SAMPLE_BITS (LEVEL_W),
        .TIME_BITS   (STAMP_W)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sensor    (s_sensor),
        .s_sample    (s_sample),
        .s_now       (s_now),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res)
    );

    // ------------------------------------------------------------------------
    // event predictor: thresholds and tracking state, all at reset values
    // ------------------------------------------------------------------------
    thresholds_t thr = DEFAULT_THR;

    bit                    armed          = 1'b0;
    logic [STAMP_W-1:0]    last_beat      = '0;
    logic [STAMP_W-1:0]    last_reject    = '0;
    logic [COUNT_BITS-1:0] beat_cnt       = '0;
    logic [COUNT_BITS-1:0] false_cnt      = '0;
    bit                    touching       = 1'b0;
    logic [STAMP_W-1:0]    touch_start    = '0;
    logic [STAMP_W-1:0]    press_stamp    = '0;
    bit                    press_seen     = 1'b0;

    function automatic bit too_many_false();
        return beat_cnt >= MIN_BEATS && 4 * int'(false_cnt) > 3 * int'(beat_cnt);
    endfunction

    // Advances the predictor by one accepted request; returns 1 with the
    // event when the request should produce one.
    function automatic bit predict_event(input sample_req_t r, output event_t ev);
        logic [STAMP_W-1:0] since_beat;
        logic [STAMP_W-1:0] since_reject;
        logic [STAMP_W-1:0] held;
        bit                 hit;
        hit          = 1'b0;
        ev           = EV_BEAT;
        since_beat   = r.stamp - last_beat;
        since_reject = r.stamp - last_reject;
        held         = r.stamp - touch_start;

        // per-request housekeeping, whatever the source
        if (since_beat >= STAMP_W'(thr.beat_window)) begin
            beat_cnt  = '0;
            false_cnt = '0;
        end
        if (too_many_false()) begin
            beat_cnt  = '0;
            false_cnt = '0;
        end

        case (r.sensor)
            SENSOR_PULSE: begin
                if (!armed) begin
                    if (r.level > thr.beat_high) begin
                        if (since_beat > STAMP_W'(thr.beat_gap)) begin
                            armed     = 1'b1;
                            last_beat = r.stamp;
                            if (beat_cnt != COUNT_MAX)
                                beat_cnt++;
                            // a beat close behind a rejected rise is suspect
                            if (since_reject <= STAMP_W'(thr.beat_gap) && false_cnt != COUNT_MAX)
                                false_cnt++;
                            if (beat_cnt >= MIN_BEATS && !too_many_false()) begin
                                ev  = EV_BEAT;
                                hit = 1'b1;
                            end
                        end else begin
                            last_reject = r.stamp;
                        end
                    end
                end else if (r.level < thr.beat_low) begin
                    armed = 1'b0;
                end
            end
            SENSOR_FORCE: begin
                if (!touching) begin
                    if (r.level > thr.touch_level) begin
                        touching    = 1'b1;
                        touch_start = r.stamp;
                    end
                end else if (r.level > thr.press_level && held >= STAMP_W'(LONG_HOLD)) begin
                    if (!press_seen || r.stamp - press_stamp > STAMP_W'(thr.repeat_gap)) begin
                        press_stamp = r.stamp;
                        press_seen  = 1'b1;
                        ev          = EV_LONG_PRESS;
                        hit         = 1'b1;
                    end
                end else if (r.level < thr.touch_level) begin
                    ev          = (held <= STAMP_W'(thr.tap_max)) ? EV_TAP : EV_LONG_STOP;
                    hit         = 1'b1;
                    press_seen  = 1'b0;
                    touching    = 1'b0;
                    touch_start = '0;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // request driver: bursts of random length with random idle gaps
    // ------------------------------------------------------------------------
    sample_req_t sample_queue[$];
    int unsigned burst_left = 1;
    int unsigned idle_left  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // slot is free: either nothing was shown or it was taken at this edge
            if (idle_left != 0) begin
                idle_left <= idle_left - 1;
                s_valid   <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                s_valid  <= 1'b1;
                s_sensor <= sample_queue[0].sensor;
                s_sample <= sample_queue[0].level;
                s_now    <= sample_queue[0].stamp;
                void'(sample_queue.pop_front());
                if (burst_left <= 1) begin
                    // long back-to-back runs now and then, short bursts otherwise
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96)
                                                              : $urandom_range(1, 12);
                    idle_left  <= $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // event receiver stalls: each span is either always ready or a random
    // rotating pattern
    // ------------------------------------------------------------------------
    int unsigned rx_span    = 0;
    logic [31:0] rx_pattern = '1;

    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_span    <= $urandom_range(16, 80);
            rx_pattern <= ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom;
        end else begin
            rx_span    <= rx_span - 1;
            rx_pattern <= {rx_pattern[0], rx_pattern[31:1]};
        end
        m_ready <= rx_pattern[0];
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted request, check every taken event
    // ------------------------------------------------------------------------
    event_t      expected_events[$];
    event_t      predicted_ev;
    int unsigned err_count = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (predict_event('{s_sensor, s_sample, s_now}, predicted_ev))
                    expected_events.push_back(predicted_ev);
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    err_count++;
                    $error("event_res: no event expected, actual %0d", m_event_res);
                end else begin
                    if (m_event_res !== expected_events[0]) begin
                        err_count++;
                        $error("event_res: expected %0d (%s), actual %0d",
                               expected_events[0], expected_events[0].name(), m_event_res);
                    end
                    void'(expected_events.pop_front());
                end
            end
        end
    end

    // run-away guard
    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    logic [STAMP_W-1:0] t_now   = 32'hFFFF_FE00;  // wraps within the directed part
    int unsigned        n_items = 0;

    task automatic push_sample(logic [1:0] sensor, logic [LEVEL_W-1:0] level,
                               int unsigned step);
        t_now += step;
        sample_queue.push_back('{sensor, level, t_now});
        n_items++;
    endtask

    function automatic logic [LEVEL_W-1:0] level_above(logic [LEVEL_W-1:0] lvl);
        return (lvl == '1) ? '1 : LEVEL_W'($urandom_range(int'(lvl) + 1, 4095));
    endfunction

    function automatic logic [LEVEL_W-1:0] level_below(logic [LEVEL_W-1:0] lvl);
        return (lvl == '0) ? '0 : LEVEL_W'($urandom_range(0, int'(lvl) - 1));
    endfunction

    // Rises spaced just past the refractory gap, with re-arm dips between
    // them; some rises are preceded by an early (rejected) rise so the next
    // beat can count as false.
    task automatic beat_train();
        int unsigned g, rises, reject_pct, at, rej_at, dip_at, next_at;
        g     = thr.beat_gap;
        rises = $urandom_range(6, 16);
        case ($urandom_range(0, 2))
            0:       reject_pct = 0;
            1:       reject_pct = 35;
            default: reject_pct = 100;
        endcase
        push_sample(SENSOR_PULSE, level_above(thr.beat_high), g + 1 + $urandom_range(0, g));
        repeat (rises) begin
            at = $urandom_range(0, g / 3);
            push_sample(SENSOR_PULSE, level_below(thr.beat_low), at);
            if ($urandom_range(0, 99) < reject_pct) begin
                rej_at = $urandom_range(at, g);
                push_sample(SENSOR_PULSE, level_above(thr.beat_high), rej_at - at);
                dip_at = $urandom_range(rej_at, g);
                push_sample(SENSOR_PULSE, level_below(thr.beat_low), dip_at - rej_at);
                at      = dip_at;
                next_at = g + 1 + $urandom_range(0, g / 2);
            end else begin
                next_at = g + 1 + $urandom_range(0, g);
            end
            push_sample(SENSOR_PULSE, level_above(thr.beat_high), next_at - at);
        end
    endtask

    // One touch: start, a spread of mostly press-level holds, then usually a release.
    task automatic touch_hold();
        int unsigned span, holds, at, step;
        case ($urandom_range(0, 3))
            0:       span = $urandom_range(0, thr.tap_max + 2);
            1:       span = thr.tap_max + $urandom_range(1, 40);
            2:       span = $urandom_range(int'(LONG_HOLD) - 10, int'(LONG_HOLD) + 10);
            default: span = int'(LONG_HOLD) + $urandom_range(0, 3 * thr.repeat_gap + 50);
        endcase
        holds = $urandom_range(0, 8);
        push_sample(SENSOR_FORCE, level_above(thr.touch_level), $urandom_range(1, 300));
        at = 0;
        for (int k = holds; k > 0; k--) begin
            step = $urandom_range(0, 2 * (span - at) / k);
            if (at + step > span)
                step = span - at;
            push_sample(SENSOR_FORCE, ($urandom_range(0, 4) == 0) ? LEVEL_W'($urandom)
                                        : level_above(thr.press_level), step);
            at += step;
        end
        // an unreleased touch now and then carries over into later requests
        if ($urandom_range(0, 7) != 0)
            push_sample(SENSOR_FORCE, level_below(thr.touch_level), span - at);
    endtask

    task automatic run_random(int unsigned count);
        int unsigned goal;
        goal = n_items + count;
        while (n_items < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: beat_train();
                4, 5, 6:    touch_hold();
                default:
                    // noise: any code, any level, odd spacing, rare far jumps in time
                    push_sample(2'($urandom), LEVEL_W'($urandom),
                                ($urandom_range(0, 15) == 0) ? $urandom
                                    : $urandom_range(0, 2 * thr.beat_gap + 2));
            endcase
        end
    endtask

    // All requests accepted and all events back; then a wait so that a request
    // that produced nothing can clear the block.
    task automatic wait_drained();
        do @(negedge aclk);
        while (sample_queue.size() != 0 || s_valid || expected_events.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic load_thresholds(thresholds_t t);
        logic [CFG_DATA_BITS-1:0] value;
        for (int i = 0; i < 8; i++) begin
            case (cfg_idx_t'(i))
                CFG_BEAT_HIGH:   value = CFG_DATA_BITS'(t.beat_high);
                CFG_BEAT_LOW:    value = CFG_DATA_BITS'(t.beat_low);
                CFG_BEAT_GAP:    value = CFG_DATA_BITS'(t.beat_gap);
                CFG_BEAT_WINDOW: value = CFG_DATA_BITS'(t.beat_window);
                CFG_TOUCH_LEVEL: value = CFG_DATA_BITS'(t.touch_level);
                CFG_PRESS_LEVEL: value = CFG_DATA_BITS'(t.press_level);
                CFG_TAP_MAX:     value = CFG_DATA_BITS'(t.tap_max);
                default:         value = CFG_DATA_BITS'(t.repeat_gap);
            endcase
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_wdata <= value;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        thr = t;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset thresholds (high 2000, low 1000, gap 300, tap 500,
        // hold 800, repeat 3000); the time base wraps through zero early on
        push_sample(SENSOR_IGNORED, 12'hFFF, 0);
        push_sample(SENSOR_SPARE,   12'h000, 1);
        push_sample(SENSOR_PULSE,   12'd2000, 1);   // at threshold: no rise
        push_sample(SENSOR_PULSE,   12'hFFF, 1);    // first beat
        push_sample(SENSOR_PULSE,   12'd1000, 5);   // at re-arm level: stays armed
        push_sample(SENSOR_PULSE,   12'd999, 5);    // re-arms
        push_sample(SENSOR_PULSE,   12'd2001, 290); // exactly one gap after: rejected
        push_sample(SENSOR_PULSE,   12'h000, 1);
        push_sample(SENSOR_PULSE,   12'hFFF, 299);  // beat one gap after the reject: false
        push_sample(SENSOR_PULSE,   12'h000, 10);
        push_sample(SENSOR_FORCE,   12'd101, 50);   // touch
        push_sample(SENSOR_FORCE,   12'd99, 500);   // release at tap limit: tap
        push_sample(SENSOR_FORCE,   12'hFFF, 10);
        push_sample(SENSOR_FORCE,   12'h000, 501);  // just past tap limit: long stop
        push_sample(SENSOR_FORCE,   12'd401, 10);
        push_sample(SENSOR_FORCE,   12'd401, 799);  // one tick short of a long press
        push_sample(SENSOR_FORCE,   12'd401, 1);    // long press
        push_sample(SENSOR_FORCE,   12'hFFF, 3000); // repeat gap not yet passed
        push_sample(SENSOR_FORCE,   12'hFFF, 1);    // repeated long press
        push_sample(SENSOR_FORCE,   12'd100, 10);   // at touch level: still held
        push_sample(SENSOR_FORCE,   12'd400, 10);   // at press level: nothing
        push_sample(SENSOR_FORCE,   12'h000, 10);   // long stop
        push_sample(SENSOR_FORCE,   12'h000, 20000);
        run_random(350);
        wait_drained();

        // tight timing
        load_thresholds('{12'd2500, 12'd1500, 16'd20, 20'd2000,
                          12'd300, 12'd3000, 16'd50, 20'd100});
        run_random(250);
        wait_drained();

        // all thresholds at zero
        load_thresholds('0);
        run_random(100);
        wait_drained();

        // thresholds at or near their maxima
        load_thresholds('{12'd4094, 12'hFFF, 16'hFFFF, 20'hF_FFFF,
                          12'd4094, 12'd4094, 16'hFFFF, 20'hF_FFFF});
        run_random(120);
        wait_drained();

        // mid-range mix
        load_thresholds('{12'd3000, 12'd200, 16'd1000, 20'd40000,
                          12'd2000, 12'd2500, 16'd2000, 20'd5000});
        run_random(200);
        wait_drained();

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
